FILE: hw/rtl/etc_pkg.sv
package etc_pkg;

  localparam int BUTTON_COUNT = 4;

  // button bit positions in a level sample
  localparam int KEY_MODIFY = 0;
  localparam int KEY_CANCEL = 1;
  localparam int KEY_DOWN   = 2;
  localparam int KEY_UP     = 3;

  localparam logic [15:0] STEP_SECONDS    = 16'd10;
  localparam logic [15:0] MIN_TARGET      = 16'd10;
  localparam logic [15:0] DOWN_THRESHOLD  = STEP_SECONDS + 16'd15;
  localparam logic [15:0] SECONDS_MAX     = 16'hFFFF;
  localparam logic [15:0] INIT_TARGET_RST = 16'd120;
  localparam logic [15:0] MAX_TARGET_RST  = 16'd3600;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INIT_TARGET = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TARGET  = 1'd1;

  localparam logic ITEM_TICK   = 1'b0;
  localparam logic ITEM_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    MODE_FRESH  = 2'd0,
    MODE_RUN    = 2'd1,
    MODE_DONE   = 2'd2,
    MODE_MODIFY = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                   mode;
    logic                    lamp_on;
    logic [15:0]             target_seconds;
    logic [15:0]             undo_target;
    logic [15:0]             elapsed_seconds;
    logic [15:0]             last_run_seconds;
    logic [BUTTON_COUNT-1:0] previous_levels;
  } timer_state_t;

  typedef struct packed {
    logic        uv_on;
    mode_t       mode;
    logic [15:0] shown_seconds;
    logic        save_strobe;
    logic [15:0] save_value;
  } timer_result_t;

endpackage

FILE: hw/rtl/exposure_timer_controller_core.sv
// Exposure timer controller: each item is a one-second tick (kind 0) or a sample of
// the four active-low buttons (kind 1), and each item yields exactly one result that
// shows the lamp, the mode and the seconds after it. One item is taken per clock
// while the output is not stalled; an item is held in the input register, and its
// result is written into the output register as the item advances. The timer state
// is updated by the step logic as each item advances. The configuration
// port is always ready; writing the initial target also reloads the current target.
module exposure_timer_controller_core (
  input  logic                                  clk,
  input  logic                                  rst,

  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  kind,
  input  logic [etc_pkg::BUTTON_COUNT-1:0]      button_levels,

  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  uv_on,
  output logic [1:0]                            mode,
  output logic [15:0]                           shown_seconds,
  output logic                                  save_strobe,
  output logic [15:0]                           save_value,

  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [etc_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [15:0]                           cfg_data
);

  logic                                 in_full;
  logic                                 in_kind;
  logic [etc_pkg::BUTTON_COUNT-1:0]     in_levels;
  logic                                 advance;
  logic                                 in_accept;
  logic                                 cfg_write;

  logic [15:0]                          max_target;

  etc_pkg::timer_state_t                state;
  etc_pkg::timer_state_t                state_next;
  etc_pkg::timer_state_t                state_load;
  etc_pkg::timer_result_t               step_result;
  etc_pkg::timer_result_t               out_result;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  // the input register moves on whenever the result register is free or drains
  assign advance   = in_full & (~out_valid | ~out_stall);
  assign in_stall  = in_full & ~advance;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_kind   <= kind;
      in_levels <= button_levels;
    end
  end

  etc_step u_step (
    .state              (state),
    .kind               (in_kind),
    .button_levels      (in_levels),
    .max_target_seconds (max_target),
    .state_next         (state_next),
    .result             (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_target <= etc_pkg::MAX_TARGET_RST;
    end else if (cfg_write && cfg_index == etc_pkg::CFG_MAX_TARGET) begin
      max_target <= cfg_data;
    end
  end

  // a write of the initial target reloads the current target
  always_comb begin
    state_load = advance ? state_next : state;
    if (cfg_write && cfg_index == etc_pkg::CFG_INIT_TARGET) begin
      state_load.target_seconds = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode             <= etc_pkg::MODE_FRESH;
      state.lamp_on          <= 1'b0;
      state.target_seconds   <= etc_pkg::INIT_TARGET_RST;
      state.undo_target      <= '0;
      state.elapsed_seconds  <= '0;
      state.last_run_seconds <= '0;
      state.previous_levels  <= '1;
    end else begin
      state <= state_load;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign uv_on         = out_result.uv_on;
  assign mode          = out_result.mode;
  assign shown_seconds = out_result.shown_seconds;
  assign save_strobe   = out_result.save_strobe;
  assign save_value    = out_result.save_value;

  // fresh is only left, never re-entered, so the lamp is off there
  assert property (@(posedge clk) disable iff (rst)
    state.mode == etc_pkg::MODE_FRESH |-> !state.lamp_on)
    else $error("lamp on in fresh mode");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_result.save_strobe |-> out_result.save_value == 16'd0)
    else $error("save value without strobe");

  assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced item lost before result register");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.mode == etc_pkg::MODE_FRESH |->
      out_result.shown_seconds == 16'd0 && !out_result.uv_on)
    else $error("fresh result shows time or lamp");

  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_full && out_valid && out_stall)
    else $error("input stalled while the path is free");

endmodule

FILE: hw/rtl/etc_step.sv
module etc_step (
  input  etc_pkg::timer_state_t              state,
  input  logic                               kind,
  input  logic [etc_pkg::BUTTON_COUNT-1:0]   button_levels,
  input  logic [15:0]                        max_target_seconds,
  output etc_pkg::timer_state_t              state_next,
  output etc_pkg::timer_result_t             result
);

  always_comb begin
    etc_pkg::timer_state_t s;
    logic [etc_pkg::BUTTON_COUNT-1:0] pressed;
    logic [16:0] raised;
    logic strobe;
    logic [15:0] saved;
    logic [15:0] shown;

    s       = state;
    pressed = state.previous_levels & ~button_levels;
    raised  = '0;
    strobe  = 1'b0;
    saved   = '0;
    shown   = '0;

    if (kind == etc_pkg::ITEM_TICK) begin
      if (s.mode == etc_pkg::MODE_RUN) begin
        if (s.elapsed_seconds != etc_pkg::SECONDS_MAX) begin
          s.elapsed_seconds = s.elapsed_seconds + 16'd1;
        end
        if (s.elapsed_seconds >= s.target_seconds) begin
          s.mode             = etc_pkg::MODE_DONE;
          s.lamp_on          = 1'b0;
          s.last_run_seconds = s.elapsed_seconds;
        end
      end
    end else begin
      s.previous_levels = button_levels;
      // presses are resolved in bit order, each one sees the mode left by the last
      for (int i = 0; i < etc_pkg::BUTTON_COUNT; i++) begin
        if (pressed[i]) begin
          if (i == etc_pkg::KEY_MODIFY) begin
            if (s.mode == etc_pkg::MODE_MODIFY) begin
              strobe = 1'b1;
              saved  = s.target_seconds;
              s.mode = etc_pkg::MODE_DONE;
            end else begin
              s.undo_target = s.target_seconds;
              s.mode        = etc_pkg::MODE_MODIFY;
            end
          end else if (s.mode != etc_pkg::MODE_MODIFY) begin
            if (s.mode != etc_pkg::MODE_RUN) begin
              s.mode            = etc_pkg::MODE_RUN;
              s.lamp_on         = 1'b1;
              s.elapsed_seconds = '0;
            end else if (i == etc_pkg::KEY_CANCEL) begin
              s.mode             = etc_pkg::MODE_DONE;
              s.lamp_on          = 1'b0;
              s.last_run_seconds = s.elapsed_seconds;
            end
          end else if (i == etc_pkg::KEY_CANCEL) begin
            s.target_seconds = s.undo_target;
            s.mode           = etc_pkg::MODE_DONE;
          end else if (i == etc_pkg::KEY_DOWN) begin
            if (s.target_seconds < etc_pkg::DOWN_THRESHOLD) begin
              s.target_seconds = etc_pkg::MIN_TARGET;
            end else begin
              s.target_seconds = s.target_seconds - etc_pkg::STEP_SECONDS;
            end
          end else if (i == etc_pkg::KEY_UP) begin
            raised = {1'b0, s.target_seconds} + {1'b0, etc_pkg::STEP_SECONDS};
            if (raised > {1'b0, max_target_seconds}) begin
              s.target_seconds = max_target_seconds;
            end else begin
              s.target_seconds = raised[15:0];
            end
          end
        end
      end
    end

    unique case (s.mode)
      etc_pkg::MODE_RUN: begin
        shown = (s.target_seconds > s.elapsed_seconds) ?
                s.target_seconds - s.elapsed_seconds : 16'd0;
      end
      etc_pkg::MODE_MODIFY: shown = s.target_seconds;
      etc_pkg::MODE_DONE:   shown = s.last_run_seconds;
      default:              shown = '0;
    endcase

    state_next           = s;
    result.uv_on         = s.lamp_on;
    result.mode          = s.mode;
    result.shown_seconds = shown;
    result.save_strobe   = strobe;
    result.save_value    = saved;
  end

endmodule

FILE: tb/sv/testbench.sv
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 4;

  logic clk;
  logic rst = 1'b1;

  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = etc_pkg::ITEM_TICK;
  logic [etc_pkg::BUTTON_COUNT-1:0] button_levels = '1;

  logic out_valid;
  logic out_stall = 1'b0;
  logic uv_on;
  logic [1:0] mode;
  logic [15:0] shown_seconds;
  logic save_strobe;
  logic [15:0] save_value;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [etc_pkg::CFG_INDEX_W-1:0] cfg_index = etc_pkg::CFG_INIT_TARGET;
  logic [15:0] cfg_data = '0;

  exposure_timer_controller_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .button_levels(button_levels),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .uv_on(uv_on),
    .mode(mode),
    .shown_seconds(shown_seconds),
    .save_strobe(save_strobe),
    .save_value(save_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // timer state as the testbench predicts it
  logic [15:0] max_target_reg = etc_pkg::MAX_TARGET_RST;
  etc_pkg::mode_t timer_mode = etc_pkg::MODE_FRESH;
  logic lamp = 1'b0;
  logic [15:0] target = etc_pkg::INIT_TARGET_RST;
  logic [15:0] undo_target = '0;
  logic [15:0] elapsed = '0;
  logic [15:0] last_runtime = '0;
  logic [etc_pkg::BUTTON_COUNT-1:0] held_levels = '1;

  etc_pkg::timer_result_t expected_results[$];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int strobes_seen = 0;
  int timed_out_runs = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold counted down here
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  function automatic void end_exposure();
    timer_mode = etc_pkg::MODE_DONE;
    lamp = 1'b0;
    last_runtime = elapsed;
  endfunction

  function automatic etc_pkg::timer_result_t advance_timer(
      logic item_kind, logic [etc_pkg::BUTTON_COUNT-1:0] levels);
    etc_pkg::timer_result_t res;
    logic [etc_pkg::BUTTON_COUNT-1:0] pressed;
    logic [16:0] raised;
    res = '0;
    if (item_kind == etc_pkg::ITEM_TICK) begin
      if (timer_mode == etc_pkg::MODE_RUN) begin
        if (elapsed != etc_pkg::SECONDS_MAX) elapsed = elapsed + 16'd1;
        if (elapsed >= target) begin
          end_exposure();
          timed_out_runs++;
        end
      end
    end else begin
      pressed = held_levels & ~levels;
      held_levels = levels;
      // presses are handled in bit order, modify first
      for (int b = 0; b < etc_pkg::BUTTON_COUNT; b++) begin
        if (!pressed[b]) continue;
        if (b == etc_pkg::KEY_MODIFY) begin
          if (timer_mode == etc_pkg::MODE_MODIFY) begin
            res.save_strobe = 1'b1;
            res.save_value = target;
            timer_mode = etc_pkg::MODE_DONE;
          end else begin
            undo_target = target;
            timer_mode = etc_pkg::MODE_MODIFY;
          end
        end else if (timer_mode != etc_pkg::MODE_MODIFY) begin
          if (timer_mode != etc_pkg::MODE_RUN) begin
            timer_mode = etc_pkg::MODE_RUN;
            lamp = 1'b1;
            elapsed = '0;
          end else if (b == etc_pkg::KEY_CANCEL) begin
            end_exposure();
          end
        end else if (b == etc_pkg::KEY_CANCEL) begin
          target = undo_target;
          timer_mode = etc_pkg::MODE_DONE;
        end else if (b == etc_pkg::KEY_DOWN) begin
          target = (target < etc_pkg::DOWN_THRESHOLD) ? etc_pkg::MIN_TARGET
                                                      : target - etc_pkg::STEP_SECONDS;
        end else begin
          raised = {1'b0, target} + {1'b0, etc_pkg::STEP_SECONDS};
          if (raised > {1'b0, max_target_reg}) raised = {1'b0, max_target_reg};
          target = raised[15:0];
        end
      end
    end
    res.uv_on = lamp;
    res.mode = timer_mode;
    case (timer_mode)
      etc_pkg::MODE_RUN: res.shown_seconds = (target > elapsed) ? target - elapsed : 16'd0;
      etc_pkg::MODE_MODIFY: res.shown_seconds = target;
      etc_pkg::MODE_DONE: res.shown_seconds = last_runtime;
      default: res.shown_seconds = '0;
    endcase
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    etc_pkg::timer_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with no item waiting");
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("uv_on", want.uv_on, uv_on);
        check_field("mode", want.mode, mode);
        check_field("shown_seconds", want.shown_seconds, shown_seconds);
        check_field("save_strobe", want.save_strobe, save_strobe);
        check_field("save_value", want.save_value, save_value);
        results_checked++;
        if (save_strobe) strobes_seen++;
      end
    end
  end

  // in_valid stays high after acceptance, so a back-to-back item needs no toggle
  task automatic send_item(logic item_kind, logic [etc_pkg::BUTTON_COUNT-1:0] levels);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= item_kind;
    button_levels <= levels;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(advance_timer(item_kind, levels));
    items_sent++;
  endtask

  task automatic press_release(int btn);
    send_item(etc_pkg::ITEM_SAMPLE, 4'hF & ~(4'h1 << btn));
    send_item(etc_pkg::ITEM_SAMPLE, 4'hF);
  endtask

  task automatic send_ticks(int count);
    repeat (count) send_item(etc_pkg::ITEM_TICK, 4'($urandom_range(15)));
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [etc_pkg::CFG_INDEX_W-1:0] index, logic [15:0] value);
    wait_all_results();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (index == etc_pkg::CFG_INIT_TARGET) begin
      target = value;
    end else begin
      max_target_reg = value;
    end
  endtask

  task automatic set_targets(logic [15:0] init_value, logic [15:0] max_value);
    write_reg(etc_pkg::CFG_INIT_TARGET, init_value);
    write_reg(etc_pkg::CFG_MAX_TARGET, max_value);
  endtask

  // reset settings: start, cancel, restart from done, modify paths
  task automatic test_button_flow();
    send_item(etc_pkg::ITEM_SAMPLE, 4'hF);
    send_ticks(1);
    press_release(etc_pkg::KEY_UP);
    send_ticks(3);
    press_release(etc_pkg::KEY_CANCEL);
    press_release(etc_pkg::KEY_DOWN);
    // modify during a run pauses it, ticks then change nothing
    press_release(etc_pkg::KEY_MODIFY);
    send_ticks(1);
    press_release(etc_pkg::KEY_UP);
    press_release(etc_pkg::KEY_MODIFY);
    press_release(etc_pkg::KEY_MODIFY);
    press_release(etc_pkg::KEY_DOWN);
    press_release(etc_pkg::KEY_CANCEL);
    // all four at once: modify, then cancel restores, then down starts a run
    send_item(etc_pkg::ITEM_SAMPLE, 4'h0);
    send_item(etc_pkg::ITEM_SAMPLE, 4'hF);
    wait_all_results();
  endtask

  task automatic test_target_limits();
    set_targets(16'd10, 16'd10);
    press_release(etc_pkg::KEY_MODIFY);
    press_release(etc_pkg::KEY_DOWN);
    press_release(etc_pkg::KEY_UP);
    press_release(etc_pkg::KEY_MODIFY);
    press_release(etc_pkg::KEY_UP);
    send_ticks(11);
    // just below and at the down threshold
    write_reg(etc_pkg::CFG_INIT_TARGET, 16'd24);
    press_release(etc_pkg::KEY_MODIFY);
    press_release(etc_pkg::KEY_DOWN);
    press_release(etc_pkg::KEY_CANCEL);
    write_reg(etc_pkg::CFG_INIT_TARGET, 16'd25);
    press_release(etc_pkg::KEY_MODIFY);
    press_release(etc_pkg::KEY_DOWN);
    press_release(etc_pkg::KEY_MODIFY);
    // target above the cap drops to the cap
    set_targets(16'hFFFF, 16'd10);
    press_release(etc_pkg::KEY_MODIFY);
    press_release(etc_pkg::KEY_UP);
    press_release(etc_pkg::KEY_MODIFY);
    set_targets(16'hFFFF, 16'hFFFF);
    press_release(etc_pkg::KEY_MODIFY);
    press_release(etc_pkg::KEY_UP);
    press_release(etc_pkg::KEY_MODIFY);
    wait_all_results();
  endtask

  task automatic test_backpressure();
    set_targets(16'd30, 16'd200);
    hold_left = 300;
    sender_idle_pct = 0;
    repeat (20) begin
      press_release($urandom_range(etc_pkg::BUTTON_COUNT-1));
      send_ticks(1);
    end
    wait_all_results();
  endtask

  task automatic random_session(int count);
    int sent;
    int pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_ticks(1);
        sent++;
      end else if (pick < 80) begin
        press_release($urandom_range(etc_pkg::BUTTON_COUNT-1));
        sent += 2;
      end else if (pick < 90) begin
        send_item(etc_pkg::ITEM_SAMPLE, 4'($urandom_range(15)));
        sent++;
      end else begin
        pick = $urandom_range(1, 20);
        send_ticks(pick);
        sent += pick;
      end
    end
  endtask

  task automatic test_random_phases();
    int idle_pct[4] = '{0, 61, 0, 10};
    int stall_pct[4] = '{0, 0, 61, 10};
    for (int p = 0; p < 4; p++) begin
      if (p == 3) set_targets(16'($urandom_range(10, 65535)), 16'($urandom_range(10, 65535)));
      else set_targets(16'($urandom_range(10, 60)), 16'($urandom_range(10, 120)));
      sender_idle_pct = idle_pct[p];
      receiver_stall_pct = stall_pct[p];
      random_session(120);
      wait_all_results();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_button_flow();
    test_target_limits();
    test_backpressure();
    test_random_phases();
    wait_all_results();
    $display("sent %0d items, checked %0d results", items_sent, results_checked);
    $display("%0d save strobes, %0d runs ended on target", strobes_seen, timed_out_runs);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/etc_pkg.sv
hw/rtl/etc_step.sv
hw/rtl/exposure_timer_controller_core.sv
tb/sv/testbench.sv
